// ----- design/mac_learning_forward_table_assert.svh -----
// Assertion macros used by the checker of the forwarding table.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH
`define MAC_LEARNING_FORWARD_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MLFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("forwarding table check failed");

// Next-cycle implication, disabled while reset is high.
`define MLFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("forwarding table check failed");

`endif

// ----- design/mlft_pkg.sv -----
// Package of the learning bridge forwarding table: sizes, entry type, state codes.
// Used by mac_learning_forward_table and its checker; depends on nothing.
package mlft_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int MAC_W       = 48;
   localparam int PORT_W      = 3;
   localparam int MASK_W      = 8;
   localparam int PCNT_W      = 4;
   localparam int FLAG_W      = 3;
   localparam int REQ_DATA_W  = ((PORT_W + 2 * MAC_W + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((MASK_W + 7) / 8) * 8;

   localparam logic [PCNT_W-1:0] PORT_COUNT_RESET = 4'd8;

   // Controller state codes.
   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE  = 3'd0;
   localparam logic [STATE_W-1:0] ST_SRC   = 3'd1;
   localparam logic [STATE_W-1:0] ST_LEARN = 3'd2;
   localparam logic [STATE_W-1:0] ST_DST   = 3'd3;
   localparam logic [STATE_W-1:0] ST_DONE  = 3'd4;

   // Bit positions of the result flags in rsp_tuser.
   localparam int FLAG_FLOODED = 0;
   localparam int FLAG_LEARNED = 1;
   localparam int FLAG_FULL    = 2;

   // One table entry: port in the upper bits, MAC in the lower bits.
   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  mac;
   } entry_type;

endpackage

// ----- design/mac_learning_forward_table.sv -----
// Top level of the learning bridge forwarding table: controller and entry memory.
// Depends on mlft_pkg for sizes, the entry type and the state codes.
//
// Each request transfer carries one frame header (arrival port, source MAC,
// destination MAC) and yields exactly one response transfer with the port
// mask and three flags. The table lives in a single synchronous memory of
// 64 entries with a registered read; entries fill in order and a
// fill count marks which are valid, so no clearing pass is needed after
// reset. A header is handled in two linear scans of the valid entries, one
// memory read per cycle: first the source MAC, then (after a possible
// learn write) the destination MAC. Scans that hit end early. The block
// works on one header at a time; the next request is taken as soon as the
// previous result sits in the output register, even if that result has not
// yet been taken. The port_count register is written through the csr
// channel, which is always ready, and must only be changed while no header
// is in flight.
module mac_learning_forward_table (
   input  logic                             clock,
   input  logic                             reset,
   // Request: {dst_mac, src_mac, in_port} from bit 0 up: in_port [2:0],
   // src_mac [50:3], dst_mac [98:51], zero fill [103:99].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mlft_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Response data: port_mask [7:0].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mlft_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Response flags: flooded [0], learned [1], table_full [2].
   output logic [mlft_pkg::FLAG_W-1:0]      rsp_tuser,
   // Configuration: port_count [3:0].
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mlft_pkg::PCNT_W-1:0]      csr_data
);

   // Entry memory, written once per learn and read once per scan cycle.
   mlft_pkg::entry_type mem [mlft_pkg::TABLE_DEPTH];

   logic [mlft_pkg::STATE_W-1:0] state_ff, state_in;
   logic [mlft_pkg::CNT_W-1:0]   ptr_ff, ptr_in;
   logic                         rd_pend_ff, rd_pend_in;
   mlft_pkg::entry_type          rd_data_ff;
   logic [mlft_pkg::CNT_W-1:0]   fill_ff, fill_in;
   logic [mlft_pkg::PCNT_W-1:0]  port_count_ff, port_count_in;

   // Header of the frame in flight.
   logic [mlft_pkg::PORT_W-1:0]  in_port_ff, in_port_in;
   logic [mlft_pkg::MAC_W-1:0]   src_ff, src_in;
   logic [mlft_pkg::MAC_W-1:0]   dst_ff, dst_in;

   // Per-frame outcome.
   logic                         hit_ff, hit_in;
   logic [mlft_pkg::PORT_W-1:0]  hit_port_ff, hit_port_in;
   logic                         learned_ff, learned_in;
   logic                         full_ff, full_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [mlft_pkg::MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [mlft_pkg::FLAG_W-1:0]  rsp_flags_ff, rsp_flags_in;

   logic                         scanning;
   logic                         issue;
   logic                         match;
   logic                         scan_end;
   logic                         learn_we;
   logic                         out_free;
   logic [mlft_pkg::MAC_W-1:0]   key;
   logic [mlft_pkg::MASK_W-1:0]  flood_mask;

   assign req_tready = (state_ff == mlft_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mlft_pkg::RSP_DATA_W'(rsp_mask_ff);
   assign rsp_tuser  = rsp_flags_ff;

   // A scan issues one read per cycle while unread valid entries remain; the
   // data comes back in the next cycle and is compared against the key.
   assign scanning = (state_ff == mlft_pkg::ST_SRC) || (state_ff == mlft_pkg::ST_DST);
   assign key      = (state_ff == mlft_pkg::ST_DST) ? dst_ff : src_ff;
   assign issue    = scanning && (ptr_ff < fill_ff);
   assign match    = rd_pend_ff && (rd_data_ff.mac == key);
   assign scan_end = !rd_pend_ff && !(ptr_ff < fill_ff);
   assign learn_we = (state_ff == mlft_pkg::ST_LEARN) &&
                     (fill_ff != mlft_pkg::CNT_W'(mlft_pkg::TABLE_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Flood to every port below port_count except the arrival port; a count
   // above eight simply enables all eight bits.
   always_comb begin
      for (int p = 0; p < mlft_pkg::MASK_W; p++) begin
         flood_mask[p] = (p < int'(port_count_ff)) && (p != int'(in_port_ff));
      end
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      rd_pend_in    = issue;
      fill_in       = fill_ff;
      port_count_in = port_count_ff;
      in_port_in    = in_port_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      hit_in        = hit_ff;
      hit_port_in   = hit_port_ff;
      learned_in    = learned_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_mask_in   = rsp_mask_ff;
      rsp_flags_in  = rsp_flags_ff;

      if (csr_valid) begin
         port_count_in = csr_data;
      end

      if (issue) begin
         ptr_in = ptr_ff + mlft_pkg::CNT_W'(1);
      end

      case (state_ff)
         mlft_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               in_port_in = req_tdata[mlft_pkg::PORT_W-1:0];
               src_in     = req_tdata[mlft_pkg::PORT_W +: mlft_pkg::MAC_W];
               dst_in     = req_tdata[mlft_pkg::PORT_W + mlft_pkg::MAC_W +: mlft_pkg::MAC_W];
               learned_in = 1'b0;
               full_in    = 1'b0;
               hit_in     = 1'b0;
               ptr_in     = '0;
               state_in   = mlft_pkg::ST_SRC;
            end
         end
         mlft_pkg::ST_SRC: begin
            // A known source is never moved; go straight to the lookup.
            if (match) begin
               ptr_in     = '0;
               rd_pend_in = 1'b0;
               state_in   = mlft_pkg::ST_DST;
            end else if (scan_end) begin
               state_in = mlft_pkg::ST_LEARN;
            end
         end
         mlft_pkg::ST_LEARN: begin
            if (learn_we) begin
               fill_in    = fill_ff + mlft_pkg::CNT_W'(1);
               learned_in = 1'b1;
            end else begin
               full_in = 1'b1;
            end
            ptr_in     = '0;
            rd_pend_in = 1'b0;
            state_in   = mlft_pkg::ST_DST;
         end
         mlft_pkg::ST_DST: begin
            if (match) begin
               hit_in      = 1'b1;
               hit_port_in = rd_data_ff.port;
               rd_pend_in  = 1'b0;
               state_in    = mlft_pkg::ST_DONE;
            end else if (scan_end) begin
               state_in = mlft_pkg::ST_DONE;
            end
         end
         mlft_pkg::ST_DONE: begin
            // Wait for the output register to free up, then hand over.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = hit_ff ? (mlft_pkg::MASK_W'(1) << hit_port_ff) : flood_mask;
               rsp_flags_in[mlft_pkg::FLAG_FLOODED] = !hit_ff;
               rsp_flags_in[mlft_pkg::FLAG_LEARNED] = learned_ff;
               rsp_flags_in[mlft_pkg::FLAG_FULL]    = full_ff;
               state_in     = mlft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlft_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mlft_pkg::ST_IDLE;
         rd_pend_ff    <= 1'b0;
         ptr_ff        <= '0;
         fill_ff       <= '0;
         port_count_ff <= mlft_pkg::PORT_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_pend_ff    <= rd_pend_in;
         ptr_ff        <= ptr_in;
         fill_ff       <= fill_in;
         port_count_ff <= port_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_port_ff   <= in_port_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      hit_ff       <= hit_in;
      hit_port_ff  <= hit_port_in;
      learned_ff   <= learned_in;
      full_ff      <= full_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   // Entry memory: the write takes the next free slot; the read is registered.
   always_ff @(posedge clock) begin
      if (learn_we) begin
         mem[fill_ff[mlft_pkg::IDX_W-1:0]] <= '{port: in_port_ff, mac: src_ff};
      end
      rd_data_ff <= mem[ptr_ff[mlft_pkg::IDX_W-1:0]];
   end

endmodule

// ----- design/mlft_checker.sv -----
// Port-level checker of the forwarding table, bound to its top level.
// Depends on mlft_pkg and mac_learning_forward_table_assert.svh.
`include "mac_learning_forward_table_assert.svh"

module mlft_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mlft_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [mlft_pkg::FLAG_W-1:0]      rsp_tuser
);

   // A stalled response keeps its flags.
   `MLFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tuser))

   // A forwarded (not flooded) frame goes to exactly one port.
   `MLFT_ASSERT_NOW(a_hit_onehot, clock, reset, rsp_tvalid && !rsp_tuser[mlft_pkg::FLAG_FLOODED], $onehot(rsp_tdata[mlft_pkg::MASK_W-1:0]))

   // A source is either learned or refused for lack of room, never both.
   `MLFT_ASSERT_NOW(a_learn_full, clock, reset, rsp_tvalid, !(rsp_tuser[mlft_pkg::FLAG_LEARNED] && rsp_tuser[mlft_pkg::FLAG_FULL]))

   // A header passes through the scan states, so the block is busy right after a transfer.
   `MLFT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind mac_learning_forward_table mlft_checker u_mlft_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/forward_table_checker.sv -----
`timescale 1ns / 1ps
// Checker for the learning bridge forwarding table. It watches the request, response and csr
// channels, predicts every response from its own copy of the table, and compares field by field.
// Depends on mlft_pkg for the field widths, the flag positions and the reset port count.
module forward_table_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [mlft_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [mlft_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [mlft_pkg::FLAG_W-1:0]     rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mlft_pkg::PCNT_W-1:0]     csr_data,
   output logic [31:0]                     fail_count,
   output logic [31:0]                     pending_results,
   output logic [31:0]                     frame_count,
   output logic [31:0]                     learn_count,
   output logic [31:0]                     full_count,
   output logic [31:0]                     flood_count
);

   typedef struct packed {
      logic [mlft_pkg::MASK_W-1:0] port_mask;
      logic                        flooded;
      logic                        learned;
      logic                        table_full;
   } fwd_decision_type;

   logic [mlft_pkg::MAC_W-1:0]  mac_table [mlft_pkg::TABLE_DEPTH];
   logic [mlft_pkg::PORT_W-1:0] port_table [mlft_pkg::TABLE_DEPTH];
   int                          entry_count = 0;
   logic [mlft_pkg::PCNT_W-1:0] port_count = mlft_pkg::PORT_COUNT_RESET;
   fwd_decision_type            decision_q [$];
   int                          fails = 0;
   int                          frames = 0;
   int                          learns = 0;
   int                          fulls = 0;
   int                          floods = 0;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      frame_count     = 0;
      learn_count     = 0;
      full_count      = 0;
      flood_count     = 0;
   end

   // Only the filled part of the table is searched, so unwritten slots are never read.
   function automatic int find_slot(input logic [mlft_pkg::MAC_W-1:0] mac);
      int slot;
      for (slot = 0; slot < entry_count; slot++)
         if (mac_table[slot] == mac)
            return slot;
      return -1;
   endfunction

   // Learn the source if it is new and there is room, then look up the destination.
   function automatic fwd_decision_type forward_frame(
         input logic [mlft_pkg::PORT_W-1:0] in_port,
         input logic [mlft_pkg::MAC_W-1:0]  src_mac,
         input logic [mlft_pkg::MAC_W-1:0]  dst_mac);
      fwd_decision_type d;
      int               dst_slot;
      int               span;
      int               p;
      d = '0;
      if (find_slot(src_mac) < 0) begin
         if (entry_count < mlft_pkg::TABLE_DEPTH) begin
            mac_table[entry_count]  = src_mac;
            port_table[entry_count] = in_port;
            entry_count++;
            d.learned = 1'b1;
         end else begin
            d.table_full = 1'b1;
         end
      end
      dst_slot = find_slot(dst_mac);
      if (dst_slot >= 0) begin
         d.port_mask = mlft_pkg::MASK_W'(1) << port_table[dst_slot];
      end else begin
         d.flooded = 1'b1;
         // Counts above the number of mask bits saturate.
         span = (port_count > mlft_pkg::MASK_W) ? mlft_pkg::MASK_W : port_count;
         for (p = 0; p < span; p++)
            if (p != in_port)
               d.port_mask[p] = 1'b1;
      end
      return d;
   endfunction

   always @(posedge clock) begin : watch_channels
      fwd_decision_type want;
      fwd_decision_type got;
      if (reset) begin
         entry_count = 0;
         port_count  = mlft_pkg::PORT_COUNT_RESET;
         decision_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            port_count = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.port_mask  = rsp_tdata[mlft_pkg::MASK_W-1:0];
            got.flooded    = rsp_tuser[mlft_pkg::FLAG_FLOODED];
            got.learned    = rsp_tuser[mlft_pkg::FLAG_LEARNED];
            got.table_full = rsp_tuser[mlft_pkg::FLAG_FULL];
            if (decision_q.size() == 0) begin
               $error("response with no frame outstanding: port_mask %h flags %b",
                      rsp_tdata, rsp_tuser);
               fails++;
            end else begin
               want = decision_q.pop_front();
               if (got.port_mask !== want.port_mask) begin
                  $error("port_mask: expected %h, got %h", want.port_mask, got.port_mask);
                  fails++;
               end
               if (got.flooded !== want.flooded) begin
                  $error("flooded: expected %b, got %b", want.flooded, got.flooded);
                  fails++;
               end
               if (got.learned !== want.learned) begin
                  $error("learned: expected %b, got %b", want.learned, got.learned);
                  fails++;
               end
               if (got.table_full !== want.table_full) begin
                  $error("table_full: expected %b, got %b", want.table_full, got.table_full);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = forward_frame(req_tdata[mlft_pkg::PORT_W-1:0],
                                 req_tdata[mlft_pkg::PORT_W +: mlft_pkg::MAC_W],
                                 req_tdata[mlft_pkg::PORT_W+mlft_pkg::MAC_W +: mlft_pkg::MAC_W]);
            decision_q.push_back(want);
            frames++;
            learns += want.learned;
            fulls  += want.table_full;
            floods += want.flooded;
         end
      end
      fail_count      <= fails;
      pending_results <= decision_q.size();
      frame_count     <= frames;
      learn_count     <= learns;
      full_count      <= fulls;
      flood_count     <= floods;
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for mac_learning_forward_table: clock, reset, frame header and csr stimulus,
// random response back-pressure and the verdict. Depends on mlft_pkg and forward_table_checker.
module tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 150;
   localparam int BLOCK_ITEMS    = 134;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [mlft_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [mlft_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [mlft_pkg::FLAG_W-1:0]     rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [mlft_pkg::PCNT_W-1:0]     csr_data   = '0;

   logic [31:0] fail_count;
   logic [31:0] pending_results;
   logic [31:0] frame_count;
   logic [31:0] learn_count;
   logic [31:0] full_count;
   logic [31:0] flood_count;

   // Percent of cycles in which the sender holds back and the receiver stalls.
   int tx_idle_pct = 36;
   int rx_idle_pct = 73;
   int quiet_cycles = 0;

   // Fixed addresses for the directed frames; all-zero and all-ones are the extremes.
   localparam logic [mlft_pkg::MAC_W-1:0] MAC_ZERO = 48'h0000_0000_0000;
   localparam logic [mlft_pkg::MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
   localparam logic [mlft_pkg::MAC_W-1:0] MAC_ODD  = 48'h5555_5555_5555;
   localparam logic [mlft_pkg::MAC_W-1:0] MAC_EVEN = 48'hAAAA_AAAA_AAAA;

   mac_learning_forward_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   forward_table_checker table_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .frame_count     (frame_count),
      .learn_count     (learn_count),
      .full_count      (full_count),
      .flood_count     (flood_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides once per cycle whether to take a response.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // The run is stuck if no transfer of any kind happens for too long. The longest
   // legal quiet stretch is a full-table scan plus a receiver stall, far below the limit.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [mlft_pkg::MAC_W-1:0] random_mac();
      return mlft_pkg::MAC_W'({$urandom, $urandom});
   endfunction

   // Present one frame header and return at the edge where its transfer happens.
   // tvalid is left high so that back-to-back headers never lower and raise it in one step.
   task automatic send_header(input logic [mlft_pkg::PORT_W-1:0] in_port,
                              input logic [mlft_pkg::MAC_W-1:0]  src_mac,
                              input logic [mlft_pkg::MAC_W-1:0]  dst_mac);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(mlft_pkg::REQ_DATA_W - mlft_pkg::PORT_W - 2 * mlft_pkg::MAC_W){1'b0}},
                     dst_mac, src_mac, in_port};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // The port count may only change while no header is in flight. Every header yields
   // a response, so the block is idle once nothing is outstanding.
   task automatic write_port_count(input logic [mlft_pkg::PCNT_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [mlft_pkg::MAC_W-1:0] mac_pool [96];
      int                         count_plan [12];
      int                         phase;
      int                         blk;
      int                         n;
      int                         pick;
      logic [mlft_pkg::MAC_W-1:0] src_mac;
      logic [mlft_pkg::MAC_W-1:0] dst_mac;

      count_plan = '{8, 1, 0, 15, 4, 9, 2, 13, 7, 3, 6, 5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed frames against a fresh table with the reset port count of eight.
      send_header(3'd0, MAC_ZERO, MAC_ONES);        // learn, unknown destination floods
      send_header(3'd7, MAC_ONES, MAC_ZERO);        // learn, hit on port 0
      send_header(3'd3, MAC_ODD, MAC_ODD);          // source equals destination: back out port 3
      send_header(3'd5, MAC_ZERO, MAC_ZERO);        // known source moved port: must stay on 0
      send_header(3'd2, MAC_EVEN, 48'h0000_0000_0001);
      send_header(3'd6, MAC_ONES, MAC_EVEN);        // hit on port 2

      // A port count of zero floods to no port at all.
      write_port_count(4'd0);
      send_header(3'd4, 48'h8000_0000_0000, 48'h0200_0000_00E1);

      // Counts above eight saturate to all eight ports.
      write_port_count(4'd15);
      send_header(3'd1, 48'h0200_0000_00E1, 48'h0200_0000_00F2);

      // With a single port in use, arrivals beyond it still learn and hits still go
      // to stored ports outside the flood range.
      write_port_count(4'd1);
      send_header(3'd0, 48'h0200_0000_00E1, 48'h0200_0000_0103);
      send_header(3'd6, 48'h0200_0000_0103, 48'h0200_0000_0114);
      send_header(3'd5, 48'h0200_0000_0114, MAC_ONES);

      write_port_count(4'd9);
      send_header(3'd7, 48'h0200_0000_0125, 48'h0200_0000_0136);

      // Random frames draw mostly on a shared address pool so that sources repeat and
      // destinations hit. The pool is larger than the table, so the table fills early
      // and later unknown sources exercise the full-table path.
      for (n = 0; n < 96; n++)
         mac_pool[n] = random_mac();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 36;
               rx_idle_pct = 73;
            end
            1: begin
               tx_idle_pct = 73;
               rx_idle_pct = 36;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         for (blk = 0; blk < 4; blk++) begin
            // Each write also drains the block, so the sender waits for every response.
            write_port_count(mlft_pkg::PCNT_W'(count_plan[phase * 4 + blk]));
            for (n = 0; n < BLOCK_ITEMS; n++) begin
               pick    = $urandom_range(0, 99);
               src_mac = (pick < 70) ? mac_pool[$urandom_range(0, 95)] : random_mac();
               pick    = $urandom_range(0, 99);
               if (pick < 65)
                  dst_mac = mac_pool[$urandom_range(0, 95)];
               else if (pick < 75)
                  dst_mac = src_mac;
               else
                  dst_mac = random_mac();
               send_header(mlft_pkg::PORT_W'($urandom_range(0, 7)), src_mac, dst_mac);
            end
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      // Give a stray extra response time to show up.
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d frame headers: %0d learned, %0d refused on a full table,",
               frame_count, learn_count, full_count);
      $display("%0d flooded, port counts from 0 to 15, with and without back-pressure.",
               flood_count);
      if (fail_count == 0 && pending_results == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
